// File: rtl/rtd_pkg.sv
package rtd_pkg;

	localparam int unsigned MAX_TASKS = 8;
	localparam int unsigned QIDX_W    = $clog2(MAX_TASKS);
	localparam int unsigned QCNT_W    = $clog2(MAX_TASKS + 1);
	localparam int unsigned PADDR_W   = 3;

	// request kinds
	localparam logic [1:0] REQ_READY = 2'd0;
	localparam logic [1:0] REQ_TICK  = 2'd1;
	localparam logic [1:0] REQ_DONE  = 2'd2;

	// scheduling policies
	localparam logic [1:0] POL_FIFO = 2'd0;
	localparam logic [1:0] POL_EDF  = 2'd1;
	localparam logic [1:0] POL_RM   = 2'd2;

	// result actions
	localparam logic [1:0] ACT_NONE     = 2'd0;
	localparam logic [1:0] ACT_DISPATCH = 2'd1;
	localparam logic [1:0] ACT_PREEMPT  = 2'd2;
	localparam logic [1:0] ACT_OVERFLOW = 2'd3;

	// register map
	localparam logic [PADDR_W-1:0] ADDR_POLICY = 3'd0;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [2:0]  task_id;
		logic [31:0] deadline;
		logic [15:0] period;
	} req_t;

	typedef struct packed {
		logic [1:0] action;
		logic [2:0] out_task;
	} rsp_t;

	typedef struct packed {
		logic [2:0]  task_id;
		logic [31:0] deadline;
		logic [15:0] period;
	} entry_t;

endpackage

// File: rtl/rtd_qmem.sv
module rtd_qmem (
	input  logic                          clk,
	input  logic                          we,
	input  logic [rtd_pkg::QIDX_W-1:0]    waddr,
	input  rtd_pkg::entry_t               wdata,
	input  logic [rtd_pkg::QIDX_W-1:0]    raddr,
	output rtd_pkg::entry_t               rdata
);

	rtd_pkg::entry_t mem_q [rtd_pkg::MAX_TASKS];
	rtd_pkg::entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/rtd_sched.sv
module rtd_sched (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [1:0]      policy,
	input  logic            req_valid,
	output logic            req_ready,
	input  rtd_pkg::req_t   req_data,
	output logic            res_valid,
	input  logic            res_ready,
	output rtd_pkg::rsp_t   res_data
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SCAN   = 3'd1;
	localparam logic [2:0] ST_DECIDE = 3'd2;
	localparam logic [2:0] ST_SHIFT  = 3'd3;
	localparam logic [2:0] ST_RESP   = 3'd4;

	logic [2:0]                   state_q;
	logic [rtd_pkg::QCNT_W-1:0]   count_q;
	logic [rtd_pkg::QIDX_W-1:0]   ptr_q;
	logic [rtd_pkg::QIDX_W-1:0]   best_idx_q;
	logic [31:0]                  best_key_q;
	rtd_pkg::entry_t              best_ent_q;
	logic                         run_valid_q;
	rtd_pkg::entry_t              run_ent_q;
	rtd_pkg::rsp_t                res_q;

	logic                         mem_we;
	logic [rtd_pkg::QIDX_W-1:0]   mem_waddr;
	rtd_pkg::entry_t              mem_wdata;
	logic [rtd_pkg::QIDX_W-1:0]   mem_raddr;
	rtd_pkg::entry_t              mem_rdata;

	logic                         fifo;
	logic                         by_period;
	logic                         accept;
	logic                         tick_go;
	logic [31:0]                  scan_key;
	logic [31:0]                  run_key;
	logic                         scan_take;
	logic                         scan_last;
	logic [rtd_pkg::QCNT_W-1:0]   ptr_inc;
	logic [rtd_pkg::QCNT_W-1:0]   ptr_inc2;
	logic [rtd_pkg::QCNT_W-1:0]   best_inc;
	logic [rtd_pkg::QCNT_W-1:0]   count_dec;

	rtd_qmem u_qmem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign fifo      = (policy == rtd_pkg::POL_FIFO);
	assign by_period = (policy == rtd_pkg::POL_RM);
	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign tick_go   = (count_q != '0) &&
	                   ((policy == rtd_pkg::POL_EDF) || (policy == rtd_pkg::POL_RM) ||
	                    (fifo && !run_valid_q));

	assign scan_key  = by_period ? {16'd0, mem_rdata.period} : mem_rdata.deadline;
	assign run_key   = by_period ? {16'd0, run_ent_q.period} : run_ent_q.deadline;
	assign ptr_inc   = {1'b0, ptr_q} + rtd_pkg::QCNT_W'(1);
	assign ptr_inc2  = {1'b0, ptr_q} + rtd_pkg::QCNT_W'(2);
	assign best_inc  = {1'b0, best_idx_q} + rtd_pkg::QCNT_W'(1);
	assign count_dec = count_q - rtd_pkg::QCNT_W'(1);
	// earliest position wins ties: only a strictly smaller key replaces
	assign scan_take = (ptr_q == '0) || (scan_key < best_key_q);
	assign scan_last = fifo || (ptr_inc == count_q);

	assign res_valid = (state_q == ST_RESP);
	assign res_data  = res_q;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = count_q[rtd_pkg::QIDX_W-1:0];
		mem_wdata = '{task_id: req_data.task_id, deadline: req_data.deadline,
		              period: req_data.period};
		mem_raddr = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept && req_data.req_type == rtd_pkg::REQ_READY &&
				    count_q < rtd_pkg::QCNT_W'(rtd_pkg::MAX_TASKS)) begin
					mem_we = 1'b1;
				end
			end
			ST_SCAN: begin
				mem_raddr = ptr_inc[rtd_pkg::QIDX_W-1:0];
			end
			ST_DECIDE: begin
				mem_raddr = best_inc[rtd_pkg::QIDX_W-1:0];
			end
			ST_SHIFT: begin
				mem_we    = 1'b1;
				mem_waddr = ptr_q;
				mem_wdata = mem_rdata;
				mem_raddr = ptr_inc2[rtd_pkg::QIDX_W-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			run_valid_q <= 1'b0;
			run_ent_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (req_data.req_type)
							rtd_pkg::REQ_READY: begin
								if (count_q < rtd_pkg::QCNT_W'(rtd_pkg::MAX_TASKS)) begin
									count_q <= count_q + rtd_pkg::QCNT_W'(1);
								end
								state_q <= ST_RESP;
							end
							rtd_pkg::REQ_DONE: begin
								run_valid_q <= 1'b0;
								state_q     <= ST_RESP;
							end
							rtd_pkg::REQ_TICK: begin
								state_q <= tick_go ? ST_SCAN : ST_RESP;
							end
							default: begin
								state_q <= ST_RESP;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (scan_last) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (fifo || !run_valid_q) begin
						run_valid_q <= 1'b1;
						run_ent_q   <= best_ent_q;
						count_q     <= count_dec;
						state_q     <= (best_inc < count_q) ? ST_SHIFT : ST_RESP;
					end else begin
						state_q <= ST_RESP;
					end
				end
				ST_SHIFT: begin
					if (!(ptr_inc < count_q)) begin
						state_q <= ST_RESP;
					end
				end
				ST_RESP: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				ptr_q <= '0;
				res_q <= '{action: rtd_pkg::ACT_NONE, out_task: 3'd0};
				if (accept && req_data.req_type == rtd_pkg::REQ_READY &&
				    !(count_q < rtd_pkg::QCNT_W'(rtd_pkg::MAX_TASKS))) begin
					res_q <= '{action: rtd_pkg::ACT_OVERFLOW, out_task: 3'd0};
				end
			end
			ST_SCAN: begin
				if (scan_take) begin
					best_key_q <= scan_key;
					best_idx_q <= ptr_q;
					best_ent_q <= mem_rdata;
				end
				ptr_q <= ptr_inc[rtd_pkg::QIDX_W-1:0];
			end
			ST_DECIDE: begin
				ptr_q <= best_idx_q;
				if (fifo || !run_valid_q) begin
					res_q <= '{action: rtd_pkg::ACT_DISPATCH, out_task: best_ent_q.task_id};
				end else if (best_key_q < run_key) begin
					res_q <= '{action: rtd_pkg::ACT_PREEMPT, out_task: best_ent_q.task_id};
				end
			end
			ST_SHIFT: begin
				ptr_q <= ptr_inc[rtd_pkg::QIDX_W-1:0];
			end
			default: begin
			end
		endcase
	end

endmodule

// File: rtl/realtime_task_dispatcher.sv
// channel   | direction | handshake                  | payload
// ----------+-----------+----------------------------+---------------------------------
// req       | in        | req_valid / req_ready      | req_data (req_type, task_id, ...)
// rsp       | out       | rsp_valid / rsp_ready      | rsp_data (action, out_task)
// apb       | in        | psel / penable / pready    | paddr, pwdata, prdata (policy)
//
// ready and done requests go straight to the result state; a tick's length is set by
// the single read port of the queue memory: one read per cycle for the
// minimum scan, then one read-write per cycle to close the gap left by the dispatched entry
// one request is in flight at a time; rsp has its own output register so a new request
// is taken while a result waits for rsp_ready
// arst_n clears the queue count, the running task and the policy; queue memory is not cleared
module realtime_task_dispatcher (
	input  logic                         clk,
	input  logic                         arst_n,
	// request channel
	input  logic                         req_valid,
	output logic                         req_ready,
	input  rtd_pkg::req_t                req_data,
	// result channel
	output logic                         rsp_valid,
	input  logic                         rsp_ready,
	output rtd_pkg::rsp_t                rsp_data,
	// configuration port
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [rtd_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);

	logic [1:0]     policy_q;
	logic           rsp_valid_q;
	rtd_pkg::rsp_t  rsp_q;
	logic           res_valid;
	logic           res_ready;
	rtd_pkg::rsp_t  res_data;
	logic           cfg_wr;

	// register file: single policy register at offset zero
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr == rtd_pkg::ADDR_POLICY) ? {30'd0, policy_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= rtd_pkg::POL_FIFO;
		end else if (cfg_wr && paddr == rtd_pkg::ADDR_POLICY) begin
			policy_q <= pwdata[1:0];
		end
	end

	// scheduler core with queue memory and running task
	rtd_sched u_sched (
		.clk       (clk),
		.arst_n    (arst_n),
		.policy    (policy_q),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data)
	);

	// output register: loads when empty or when the held result is taken
	assign res_ready = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_ready) begin
			rsp_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			rsp_q <= res_data;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

endmodule

// File: dv/tb.sv
module tb;

	// request kind and policy codes that the block treats as unused
	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam logic [1:0] POL_UNUSED = 2'd3;

	// tick worst case plus margin, used for the final settle
	localparam int unsigned SETTLE_CYCLES = 2 * rtd_pkg::MAX_TASKS + 8;

	// predicts the dispatcher and holds the results it still owes
	class dispatch_checker;
		rtd_pkg::entry_t ready_list[rtd_pkg::MAX_TASKS];
		int unsigned     ready_count;
		bit              cpu_busy;
		rtd_pkg::entry_t cpu_entry;
		logic [1:0]      policy;
		rtd_pkg::rsp_t   predicted_rsp[$];
		int unsigned     mismatches;
		int unsigned     results_seen;

		function new();
			ready_count  = 0;
			cpu_busy     = 1'b0;
			cpu_entry    = '0;
			policy       = rtd_pkg::POL_FIFO;
			mismatches   = 0;
			results_seen = 0;
		endfunction

		function void set_policy(logic [1:0] value);
			policy = value;
		endfunction

		function logic [31:0] sort_key(rtd_pkg::entry_t e, bit by_period);
			return by_period ? 32'(e.period) : e.deadline;
		endfunction

		// move entry idx to the processor and close the gap
		function void take_entry(int unsigned idx);
			cpu_busy  = 1'b1;
			cpu_entry = ready_list[idx];
			for (int unsigned k = idx; k + 1 < ready_count; k++)
				ready_list[k] = ready_list[k + 1];
			ready_count--;
		endfunction

		function void note_request(rtd_pkg::req_t r);
			rtd_pkg::rsp_t res;
			bit            by_period;
			int unsigned   best;
			res = '0;
			res.action = rtd_pkg::ACT_NONE;
			case (r.req_type)
				rtd_pkg::REQ_READY: begin
					if (ready_count >= rtd_pkg::MAX_TASKS) begin
						res.action = rtd_pkg::ACT_OVERFLOW;
					end else begin
						ready_list[ready_count] = '{r.task_id, r.deadline, r.period};
						ready_count++;
					end
				end
				rtd_pkg::REQ_DONE: begin
					cpu_busy = 1'b0;
				end
				rtd_pkg::REQ_TICK: begin
					if (ready_count > 0) begin
						if (policy == rtd_pkg::POL_FIFO) begin
							if (!cpu_busy) begin
								res.action   = rtd_pkg::ACT_DISPATCH;
								res.out_task = ready_list[0].task_id;
								take_entry(0);
							end
						end else if (policy == rtd_pkg::POL_EDF || policy == rtd_pkg::POL_RM) begin
							by_period = (policy == rtd_pkg::POL_RM);
							best = 0;
							for (int unsigned k = 1; k < ready_count; k++)
								if (sort_key(ready_list[k], by_period) <
										sort_key(ready_list[best], by_period))
									best = k;
							if (!cpu_busy) begin
								res.action   = rtd_pkg::ACT_DISPATCH;
								res.out_task = ready_list[best].task_id;
								take_entry(best);
							end else if (sort_key(ready_list[best], by_period) <
									sort_key(cpu_entry, by_period)) begin
								res.action   = rtd_pkg::ACT_PREEMPT;
								res.out_task = ready_list[best].task_id;
							end
						end
					end
				end
				default: ;
			endcase
			predicted_rsp.push_back(res);
		endfunction

		task report(string msg);
			mismatches++;
			$display("mismatch: %s", msg);
		endtask

		task check_result(rtd_pkg::rsp_t got);
			rtd_pkg::rsp_t want;
			results_seen++;
			if (predicted_rsp.size() == 0) begin
				report($sformatf("result %0d with nothing pending: action %0d task %0d",
					results_seen, got.action, got.out_task));
				return;
			end
			want = predicted_rsp.pop_front();
			if (got.action !== want.action)
				report($sformatf("result %0d action %0d, predicted %0d",
					results_seen, got.action, want.action));
			if (got.out_task !== want.out_task)
				report($sformatf("result %0d out_task %0d, predicted %0d",
					results_seen, got.out_task, want.out_task));
		endtask
	endclass

	logic          clk;
	logic          arst_n;
	logic          req_valid;
	logic          req_ready;
	rtd_pkg::req_t req_data;
	logic          rsp_valid;
	logic          rsp_ready;
	rtd_pkg::rsp_t rsp_data;
	logic          psel;
	logic          penable;
	logic          pwrite;
	logic [rtd_pkg::PADDR_W-1:0] paddr;
	logic [31:0]   pwdata;
	logic [31:0]   prdata;
	logic          pready;

	dispatch_checker sb;

	// idling on both sides, switched off for the closing stretch
	bit idle_on;
	// long receiver hold-off, counted down by the receiver
	int hold_left;

	realtime_task_dispatcher i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	// clock, period 20
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// hard stop well past the slowest legal run
	initial begin
		#(20 * 800000);
		$display("FAIL");
		$finish;
	end

	// build one request
	function automatic rtd_pkg::req_t make_req(logic [1:0] kind, logic [2:0] id,
			logic [31:0] dl, logic [15:0] per);
		rtd_pkg::req_t r;
		r.req_type = kind;
		r.task_id  = id;
		r.deadline = dl;
		r.period   = per;
		return r;
	endfunction

	// random request, weights in percent; small value sets force key ties
	function automatic rtd_pkg::req_t random_req(int ready_pct, int tick_pct);
		rtd_pkg::req_t r;
		int            pick;
		pick = $urandom_range(0, 99);
		if (pick < 3)
			r.req_type = REQ_UNUSED;
		else if (pick < 3 + ready_pct)
			r.req_type = rtd_pkg::REQ_READY;
		else if (pick < 3 + ready_pct + tick_pct)
			r.req_type = rtd_pkg::REQ_TICK;
		else
			r.req_type = rtd_pkg::REQ_DONE;
		r.task_id = 3'($urandom_range(0, 7));
		case ($urandom_range(0, 3))
			0: r.deadline = 32'($urandom_range(0, 15));
			1: r.deadline = $urandom_range(0, 1) ? 32'hffff_ffff : 32'd0;
			default: r.deadline = $urandom();
		endcase
		case ($urandom_range(0, 3))
			0: r.period = 16'($urandom_range(0, 7));
			1: begin
				case ($urandom_range(0, 2))
					0: r.period = 16'd0;
					1: r.period = 16'd1;
					default: r.period = 16'hffff;
				endcase
			end
			default: r.period = 16'($urandom_range(1, 65535));
		endcase
		return r;
	endfunction

	// offer one request, with an optional idle burst first; returns once accepted
	task automatic send_request(input rtd_pkg::req_t r);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_data  <= r;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		sb.note_request(r);
	endtask

	// stop offering and wait until every predicted result is back
	task automatic drain_results();
		req_valid <= 1'b0;
		while (sb.predicted_rsp.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// write of the policy register: setup phase, then access phase
	task automatic write_policy(input logic [1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= rtd_pkg::ADDR_POLICY;
		pwdata  <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		sb.set_policy(value);
	endtask

	// idle the block, then switch policy
	task automatic change_policy(input logic [1:0] value);
		drain_results();
		write_policy(value);
	endtask

	// random phase; ignored request kinds are not counted
	task automatic run_random(input int count, input int ready_pct, input int tick_pct);
		rtd_pkg::req_t r;
		int            sent;
		sent = 0;
		while (sent < count) begin
			r = random_req(ready_pct, tick_pct);
			send_request(r);
			if (r.req_type != REQ_UNUSED)
				sent++;
		end
	endtask

	// receiver: checks every accepted result and decides rsp_ready for the next edge
	initial begin
		int stall_left;
		stall_left = 0;
		rsp_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_valid && rsp_ready)
				sb.check_result(rsp_data);
			if (hold_left > 0) begin
				// long hold-off so the output register and the request slot both fill
				hold_left--;
				rsp_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp_ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 6) - 1;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	// main sequence
	initial begin
		sb        = new();
		idle_on   = 1'b1;
		hold_left = 0;
		arst_n    <= 1'b0;
		req_valid <= 1'b0;
		req_data  <= '0;
		psel      <= 1'b0;
		penable   <= 1'b0;
		pwrite    <= 1'b0;
		paddr     <= '0;
		pwdata    <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, first-come order straight out of reset
		// tick on an empty queue, done while idle, unused request kind
		send_request(make_req(rtd_pkg::REQ_TICK, 3'd5, 32'd0, 16'd0));
		send_request(make_req(rtd_pkg::REQ_DONE, 3'd7, 32'hffff_ffff, 16'hffff));
		send_request(make_req(REQ_UNUSED, 3'd2, 32'h1234_5678, 16'h00ff));
		// fill the queue: field extremes, period zero, deadline and period ties
		send_request(make_req(rtd_pkg::REQ_READY, 3'd7, 32'hffff_ffff, 16'hffff));
		send_request(make_req(rtd_pkg::REQ_READY, 3'd1, 32'd100, 16'd0));
		send_request(make_req(rtd_pkg::REQ_READY, 3'd2, 32'd0, 16'd300));
		send_request(make_req(rtd_pkg::REQ_READY, 3'd3, 32'd5, 16'd200));
		send_request(make_req(rtd_pkg::REQ_READY, 3'd0, 32'h8000_0000, 16'h8000));
		send_request(make_req(rtd_pkg::REQ_READY, 3'd5, 32'd7, 16'd0));
		send_request(make_req(rtd_pkg::REQ_READY, 3'd6, 32'hffff_fffe, 16'd1));
		send_request(make_req(rtd_pkg::REQ_READY, 3'd4, 32'd0, 16'hfffe));
		// queue full, request dropped
		send_request(make_req(rtd_pkg::REQ_READY, 3'd3, 32'd0, 16'd0));
		// dispatch the head, then a tick while busy does nothing
		send_request(make_req(rtd_pkg::REQ_TICK, 3'd0, 32'd0, 16'd0));
		send_request(make_req(rtd_pkg::REQ_TICK, 3'd0, 32'd0, 16'd0));

		// earliest deadline first: preempt the running task, then dispatch by deadline
		change_policy(rtd_pkg::POL_EDF);
		send_request(make_req(rtd_pkg::REQ_TICK, 3'd0, 32'd0, 16'd0));
		send_request(make_req(rtd_pkg::REQ_DONE, 3'd0, 32'd0, 16'd0));
		send_request(make_req(rtd_pkg::REQ_TICK, 3'd0, 32'd0, 16'd0));

		// rate monotonic: compare by period
		change_policy(rtd_pkg::POL_RM);
		send_request(make_req(rtd_pkg::REQ_TICK, 3'd0, 32'd0, 16'd0));
		send_request(make_req(rtd_pkg::REQ_DONE, 3'd0, 32'd0, 16'd0));
		send_request(make_req(rtd_pkg::REQ_TICK, 3'd0, 32'd0, 16'd0));

		// unused policy: ticks do nothing
		change_policy(POL_UNUSED);
		send_request(make_req(rtd_pkg::REQ_DONE, 3'd0, 32'd0, 16'd0));
		send_request(make_req(rtd_pkg::REQ_TICK, 3'd0, 32'd0, 16'd0));
		send_request(make_req(rtd_pkg::REQ_READY, 3'd6, 32'd9, 16'd9));
		send_request(make_req(rtd_pkg::REQ_TICK, 3'd0, 32'd0, 16'd0));

		// random phases across all settings
		change_policy(rtd_pkg::POL_EDF);
		run_random(250, 45, 40);
		change_policy(rtd_pkg::POL_RM);
		run_random(250, 45, 40);
		change_policy(rtd_pkg::POL_FIFO);
		run_random(150, 45, 40);

		// ready-heavy phase with a long receiver hold-off while requests keep coming
		change_policy(rtd_pkg::POL_RM);
		hold_left = 300;
		run_random(120, 70, 20);

		// tick-heavy phase, then random phases under the other settings
		change_policy(rtd_pkg::POL_EDF);
		run_random(150, 25, 60);
		change_policy(POL_UNUSED);
		run_random(40, 45, 40);
		change_policy(rtd_pkg::POL_FIFO);
		run_random(120, 45, 40);
		change_policy(rtd_pkg::POL_EDF);
		run_random(200, 45, 40);

		// closing stretch with no idling on either side
		change_policy(rtd_pkg::POL_RM);
		idle_on = 1'b0;
		run_random(150, 45, 40);

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.predicted_rsp.size() != 0)
			sb.report($sformatf("%0d predicted results never arrived",
				sb.predicted_rsp.size()));
		if (sb.mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// File: files.f
rtl/rtd_pkg.sv
rtl/rtd_qmem.sv
rtl/rtd_sched.sv
rtl/realtime_task_dispatcher.sv
dv/tb.sv
